>>> src/mesh_xy_route_compute_macros.svh
// Assertion macros for the mesh XY route compute block.
// Used by src/mesh_xy_route_compute.sv; expects clk and rst_n in scope.
`ifndef MESH_XY_ROUTE_COMPUTE_MACROS_SVH
`define MESH_XY_ROUTE_COMPUTE_MACROS_SVH

// Check a property at every clock edge outside reset.
`define MXY_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition at one edge implies another at the next edge.
`define MXY_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/mxy_pkg.sv
// Types, codes and division step functions for the mesh XY route compute block.
// No dependencies; used by src/mesh_xy_route_compute.sv.
`default_nettype none

package mxy_pkg;

    localparam int MAX_PORTS    = 16;
    localparam int ROUTER_PORTS = 4;

    localparam int DEST_W     = 16;
    localparam int RN_W       = 12;
    localparam int LPC_W      = 4;
    localparam int PT_W       = 5;
    localparam int MW_W       = 13;
    localparam int MASK_W     = 16;
    localparam int PORT_W     = 4;
    localparam int STAT_W     = 2;
    localparam int USE_W      = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [PORT_W-1:0] DIR_NORTH = 4'd0;
    localparam logic [PORT_W-1:0] DIR_EAST  = 4'd1;
    localparam logic [PORT_W-1:0] DIR_SOUTH = 4'd2;
    localparam logic [PORT_W-1:0] DIR_WEST  = 4'd3;

    localparam logic [STAT_W-1:0] STAT_OK          = 2'd0;
    localparam logic [STAT_W-1:0] STAT_BAD_DEST    = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BAD_ARRIVAL = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROUTER_NUMBER    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_PORT_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PORT_TOTAL       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MESH_WIDTH       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CONNECTED_MASK   = 3'd4;

    localparam int DIV1_STEPS  = 4;
    localparam int DIV1_STAGES = DEST_W / DIV1_STEPS;
    localparam int DIV2_STEPS  = 2;
    localparam int DIV2_STAGES = DEST_W / DIV2_STEPS;
    localparam int NUM_STAGES  = DIV1_STAGES + DIV2_STAGES + 1;

    typedef struct packed {
        logic [LPC_W-1:0]  rem;
        logic [DEST_W-1:0] quo;
    } div1_t;

    typedef struct packed {
        logic [MW_W-1:0]   rem;
        logic [DEST_W-1:0] quo;
    } div2_t;

    typedef struct packed {
        logic              action;
        logic [MASK_W-1:0] mask;
        logic [STAT_W-1:0] status;
        logic [PORT_W-1:0] port;
        div1_t             dest_div;
        div2_t             rtr_div;
        div2_t             home_div;
    } pipe_t;

    typedef struct packed {
        logic [PORT_W-1:0] port;
        logic [MASK_W-1:0] mask;
        logic [STAT_W-1:0] status;
    } rsp_t;

    function automatic div1_t div1_step(div1_t cur, logic [LPC_W-1:0] divisor);
        logic [LPC_W:0] trial;
        div1_t          nxt;
        trial = {cur.rem, cur.quo[DEST_W-1]};
        nxt.quo = {cur.quo[DEST_W-2:0], 1'b0};
        if (trial >= {1'b0, divisor})
        begin
            trial = trial - {1'b0, divisor};
            nxt.quo[0] = 1'b1;
        end
        nxt.rem = trial[LPC_W-1:0];
        return nxt;
    endfunction

    function automatic div2_t div2_step(div2_t cur, logic [MW_W-1:0] divisor);
        logic [MW_W:0] trial;
        div2_t         nxt;
        trial = {cur.rem, cur.quo[DEST_W-1]};
        nxt.quo = {cur.quo[DEST_W-2:0], 1'b0};
        if (trial >= {1'b0, divisor})
        begin
            trial = trial - {1'b0, divisor};
            nxt.quo[0] = 1'b1;
        end
        nxt.rem = trial[MW_W-1:0];
        return nxt;
    endfunction

endpackage

`default_nettype wire

>>> src/mesh_xy_route_compute.sv
// XY dimension-order route compute for one mesh router, with its config registers.
// Depends on src/mxy_pkg.sv and src/mesh_xy_route_compute_macros.svh.
//
// One header is accepted every cycle while req_stall is low (skid buffer empty):
// four pipeline stages divide the destination by the local port count (four
// quotient bits each), eight more split the destination router into x and y
// by the mesh width (two quotient bits each, with the home router split
// alongside), one stage picks the port, and an output register with a
// one-entry skid buffer holds results while the far side stalls. Config
// writes are taken in any cycle (cfg_ready is always high) and must be made
// only while no header is in flight. No clearing pass runs after reset.
`default_nettype none

`include "mesh_xy_route_compute_macros.svh"

module mesh_xy_route_compute
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,

    input  wire logic                            cfg_valid,
    output      logic                            cfg_ready,
    input  wire logic [mxy_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [mxy_pkg::CFG_DATA_W-1:0]  cfg_data,

    input  wire logic                            req_valid,
    output      logic                            req_stall,
    input  wire logic                            action,
    input  wire logic [mxy_pkg::DEST_W-1:0]      destination,
    input  wire logic [mxy_pkg::PORT_W-1:0]      arrival_port,

    output      logic                            rsp_valid,
    input  wire logic                            rsp_stall,
    output      logic [mxy_pkg::PORT_W-1:0]      out_port,
    output      logic [mxy_pkg::MASK_W-1:0]      forward_mask,
    output      logic [mxy_pkg::STAT_W-1:0]      status
);

    localparam int N = mxy_pkg::NUM_STAGES;

    logic [mxy_pkg::RN_W-1:0]   router_number_reg;
    logic [mxy_pkg::LPC_W-1:0]  local_port_count_reg;
    logic [mxy_pkg::PT_W-1:0]   port_total_reg;
    logic [mxy_pkg::MW_W-1:0]   mesh_width_reg;
    logic [mxy_pkg::MASK_W-1:0] connected_mask_reg;

    logic [mxy_pkg::LPC_W-1:0]  lpc_eff;
    logic [mxy_pkg::MW_W-1:0]   width_eff;
    logic [mxy_pkg::USE_W-1:0]  usable_ports;

    mxy_pkg::pipe_t             entry;
    mxy_pkg::pipe_t             stage_in   [N];
    mxy_pkg::pipe_t             pipe_next  [N];
    mxy_pkg::pipe_t             pipe_reg   [N];
    logic [N-1:0]               pipe_valid_reg;
    logic [N-1:0]               pipe_valid_next;
    logic                       pipe_en;
    logic                       req_accept;

    mxy_pkg::rsp_t              last_rsp;
    logic                       last_valid;
    mxy_pkg::rsp_t              out_reg;
    mxy_pkg::rsp_t              skid_reg;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic                       skid_valid_reg;
    logic                       skid_valid_next;
    logic                       out_load_pipe;
    logic                       out_load_skid;
    logic                       skid_load;
    logic                       rsp_xfer;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            router_number_reg    <= '0;
            local_port_count_reg <= mxy_pkg::LPC_W'(1);
            port_total_reg       <= mxy_pkg::PT_W'(5);
            mesh_width_reg       <= mxy_pkg::MW_W'(1);
            connected_mask_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                mxy_pkg::CFG_ROUTER_NUMBER:
                    router_number_reg <= cfg_data[mxy_pkg::RN_W-1:0];
                mxy_pkg::CFG_LOCAL_PORT_COUNT:
                    local_port_count_reg <= cfg_data[mxy_pkg::LPC_W-1:0];
                mxy_pkg::CFG_PORT_TOTAL:
                    port_total_reg <= cfg_data[mxy_pkg::PT_W-1:0];
                mxy_pkg::CFG_MESH_WIDTH:
                    mesh_width_reg <= cfg_data[mxy_pkg::MW_W-1:0];
                mxy_pkg::CFG_CONNECTED_MASK:
                    connected_mask_reg <= cfg_data[mxy_pkg::MASK_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign lpc_eff   = (local_port_count_reg == '0) ? mxy_pkg::LPC_W'(1) : local_port_count_reg;
    assign width_eff = (mesh_width_reg == '0) ? mxy_pkg::MW_W'(1) : mesh_width_reg;
    assign usable_ports = (port_total_reg > mxy_pkg::PT_W'(mxy_pkg::MAX_PORTS))
                        ? mxy_pkg::USE_W'(mxy_pkg::MAX_PORTS) : port_total_reg;

    assign pipe_en    = !skid_valid_reg;
    assign req_stall  = skid_valid_reg;
    assign req_accept = req_valid && !req_stall;

    // Broadcast mask and item load into the first stage.
    always_comb
    begin
        entry = '0;
        entry.action = action;
        entry.dest_div.quo = destination;
        entry.status = mxy_pkg::STAT_OK;
        for (int i = mxy_pkg::ROUTER_PORTS; i < mxy_pkg::MASK_W; i++)
        begin
            if ((mxy_pkg::USE_W'(i) < usable_ports) && (mxy_pkg::PORT_W'(i) != arrival_port)
                && connected_mask_reg[i])
            begin
                entry.mask[i] = 1'b1;
            end
        end
        if (arrival_port >= mxy_pkg::PORT_W'(mxy_pkg::ROUTER_PORTS))
        begin
            entry.mask[mxy_pkg::ROUTER_PORTS-1:0] =
                connected_mask_reg[mxy_pkg::ROUTER_PORTS-1:0];
            if ({1'b0, arrival_port} >= usable_ports)
            begin
                entry.status = mxy_pkg::STAT_BAD_ARRIVAL;
            end
        end
        else if (arrival_port == mxy_pkg::DIR_NORTH)
        begin
            entry.mask[mxy_pkg::DIR_SOUTH] = connected_mask_reg[mxy_pkg::DIR_SOUTH];
        end
        else if (arrival_port == mxy_pkg::DIR_SOUTH)
        begin
            entry.mask[mxy_pkg::DIR_NORTH] = connected_mask_reg[mxy_pkg::DIR_NORTH];
        end
        else
        begin
            for (int i = 0; i < mxy_pkg::ROUTER_PORTS; i++)
            begin
                if ((mxy_pkg::PORT_W'(i) != arrival_port) && connected_mask_reg[i])
                begin
                    entry.mask[i] = 1'b1;
                end
            end
        end
    end

    for (genvar s = 0; s < N; s++)
    begin : g_stage
        if (s == 0)
        begin : g_first
            assign stage_in[s] = entry;
        end
        else
        begin : g_link
            assign stage_in[s] = pipe_reg[s-1];
        end

        if (s < mxy_pkg::DIV1_STAGES)
        begin : g_div1
            always_comb
            begin
                pipe_next[s] = stage_in[s];
                for (int j = 0; j < mxy_pkg::DIV1_STEPS; j++)
                begin
                    pipe_next[s].dest_div = mxy_pkg::div1_step(pipe_next[s].dest_div, lpc_eff);
                end
            end
        end
        else if (s < mxy_pkg::DIV1_STAGES + mxy_pkg::DIV2_STAGES)
        begin : g_div2
            always_comb
            begin
                pipe_next[s] = stage_in[s];
                if (s == mxy_pkg::DIV1_STAGES)
                begin
                    pipe_next[s].rtr_div.rem  = '0;
                    pipe_next[s].rtr_div.quo  = stage_in[s].dest_div.quo;
                    pipe_next[s].home_div.rem = '0;
                    pipe_next[s].home_div.quo = mxy_pkg::DEST_W'(router_number_reg);
                end
                for (int j = 0; j < mxy_pkg::DIV2_STEPS; j++)
                begin
                    pipe_next[s].rtr_div  = mxy_pkg::div2_step(pipe_next[s].rtr_div, width_eff);
                    pipe_next[s].home_div = mxy_pkg::div2_step(pipe_next[s].home_div, width_eff);
                end
            end
        end
        else
        begin : g_pick
            logic [mxy_pkg::USE_W-1:0] local_port;

            assign local_port = {1'b0, stage_in[s].dest_div.rem}
                              + mxy_pkg::USE_W'(mxy_pkg::ROUTER_PORTS);

            always_comb
            begin
                pipe_next[s] = stage_in[s];
                pipe_next[s].port = mxy_pkg::DIR_NORTH;
                if (!stage_in[s].action)
                begin
                    pipe_next[s].mask   = '0;
                    pipe_next[s].status = mxy_pkg::STAT_OK;
                    priority if (stage_in[s].rtr_div.rem < stage_in[s].home_div.rem)
                        pipe_next[s].port = mxy_pkg::DIR_WEST;
                    else if (stage_in[s].rtr_div.rem > stage_in[s].home_div.rem)
                        pipe_next[s].port = mxy_pkg::DIR_EAST;
                    else if (stage_in[s].rtr_div.quo < stage_in[s].home_div.quo)
                        pipe_next[s].port = mxy_pkg::DIR_SOUTH;
                    else if (stage_in[s].rtr_div.quo > stage_in[s].home_div.quo)
                        pipe_next[s].port = mxy_pkg::DIR_NORTH;
                    else if (local_port >= usable_ports)
                        pipe_next[s].status = mxy_pkg::STAT_BAD_DEST;
                    else
                        pipe_next[s].port = local_port[mxy_pkg::PORT_W-1:0];
                end
            end
        end
    end

    assign pipe_valid_next = {pipe_valid_reg[N-2:0], req_accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pipe_valid_reg <= '0;
        end
        else if (pipe_en)
        begin
            pipe_valid_reg <= pipe_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            pipe_reg <= pipe_next;
        end
    end

    assign last_valid      = pipe_valid_reg[N-1];
    assign last_rsp.port   = pipe_reg[N-1].port;
    assign last_rsp.mask   = pipe_reg[N-1].mask;
    assign last_rsp.status = pipe_reg[N-1].status;
    assign rsp_xfer        = out_valid_reg && !rsp_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_load_pipe   = 1'b0;
        out_load_skid   = 1'b0;
        skid_load       = 1'b0;
        if (skid_valid_reg)
        begin
            if (rsp_xfer)
            begin
                out_load_skid   = 1'b1;
                skid_valid_next = 1'b0;
            end
        end
        else if (!out_valid_reg || rsp_xfer)
        begin
            out_valid_next = last_valid;
            out_load_pipe  = last_valid;
        end
        else if (last_valid)
        begin
            skid_valid_next = 1'b1;
            skid_load       = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load_skid)
        begin
            out_reg <= skid_reg;
        end
        else if (out_load_pipe)
        begin
            out_reg <= last_rsp;
        end
        if (skid_load)
        begin
            skid_reg <= last_rsp;
        end
    end

    assign rsp_valid    = out_valid_reg;
    assign out_port     = out_reg.port;
    assign forward_mask = out_reg.mask;
    assign status       = out_reg.status;

    `MXY_ASSERT(a_skid_fill, $rose(skid_valid_reg) |-> $past(rsp_valid && rsp_stall), "skid filled without a stalled result")
    `MXY_ASSERT(a_skid_behind_out, skid_valid_reg |-> out_valid_reg, "skid holds a result while output is empty")
    `MXY_ASSERT_NEXT(a_pipe_hold, !pipe_en, $stable(pipe_valid_reg), "pipeline moved while held")
    `MXY_ASSERT(a_bad_dest, (rsp_valid && (status == mxy_pkg::STAT_BAD_DEST)) |-> ((out_port == mxy_pkg::DIR_NORTH) && (forward_mask == '0)), "bad destination with nonzero port or mask")
    `MXY_ASSERT(a_bad_arrival, (rsp_valid && (status == mxy_pkg::STAT_BAD_ARRIVAL)) |-> (out_port == mxy_pkg::DIR_NORTH), "bad arrival with nonzero port")

endmodule

`default_nettype wire

>>> dv/mesh_route_checker.sv
`timescale 1ns / 1ps
// Checker for the mesh XY route compute block: watches config, request and response transfers.
// Predicts each route result from its own copy of the registers; depends on mxy_pkg.

module mesh_route_checker
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    input  wire logic                           cfg_ready,
    input  wire logic [mxy_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [mxy_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           req_valid,
    input  wire logic                           req_stall,
    input  wire logic                           action,
    input  wire logic [mxy_pkg::DEST_W-1:0]     destination,
    input  wire logic [mxy_pkg::PORT_W-1:0]     arrival_port,
    input  wire logic                           rsp_valid,
    input  wire logic                           rsp_stall,
    input  wire logic [mxy_pkg::PORT_W-1:0]     out_port,
    input  wire logic [mxy_pkg::MASK_W-1:0]     forward_mask,
    input  wire logic [mxy_pkg::STAT_W-1:0]     status,
    output int                                  fail_count,
    output int                                  pending
);

    logic [mxy_pkg::RN_W-1:0]   router_number_q;
    logic [mxy_pkg::LPC_W-1:0]  local_ports_q;
    logic [mxy_pkg::PT_W-1:0]   port_total_q;
    logic [mxy_pkg::MW_W-1:0]   mesh_width_q;
    logic [mxy_pkg::MASK_W-1:0] connected_q;

    mxy_pkg::rsp_t expected_routes[$];
    mxy_pkg::rsp_t oldest_route;

    function automatic mxy_pkg::rsp_t predict_route(logic act,
                                                    logic [mxy_pkg::DEST_W-1:0] dest,
                                                    logic [mxy_pkg::PORT_W-1:0] arr);
        int unsigned lpc, w, dest_rtr, dx, dy, hx, hy, port, usable;
        logic [mxy_pkg::MASK_W-1:0] mask;
        mxy_pkg::rsp_t r;
        r.port = '0;
        r.mask = '0;
        r.status = mxy_pkg::STAT_OK;
        mask = '0;
        usable = port_total_q;
        if (usable > mxy_pkg::MAX_PORTS)
            usable = mxy_pkg::MAX_PORTS;
        if (usable > 16)
            usable = 16;
        if (!act)
        begin
            lpc = (local_ports_q == 0) ? 1 : local_ports_q;
            w = (mesh_width_q == 0) ? 1 : mesh_width_q;
            dest_rtr = dest / lpc;
            if (dest_rtr != router_number_q)
            begin
                dx = dest_rtr % w;
                dy = dest_rtr / w;
                hx = router_number_q % w;
                hy = router_number_q / w;
                if (dx < hx)
                    r.port = mxy_pkg::DIR_WEST;
                else if (dx > hx)
                    r.port = mxy_pkg::DIR_EAST;
                else if (dy < hy)
                    r.port = mxy_pkg::DIR_SOUTH;
                else
                    r.port = mxy_pkg::DIR_NORTH;
            end
            else
            begin
                port = dest - router_number_q * lpc + mxy_pkg::ROUTER_PORTS;
                if (port >= usable)
                    r.status = mxy_pkg::STAT_BAD_DEST;
                else
                    r.port = mxy_pkg::PORT_W'(port);
            end
        end
        else
        begin
            for (int i = mxy_pkg::ROUTER_PORTS; i < usable; i++)
                if (i != arr && connected_q[i])
                    mask[i] = 1'b1;
            if (arr >= mxy_pkg::ROUTER_PORTS)
            begin
                mask[mxy_pkg::ROUTER_PORTS-1:0] = mask[mxy_pkg::ROUTER_PORTS-1:0]
                                                | connected_q[mxy_pkg::ROUTER_PORTS-1:0];
                if (arr >= usable)
                    r.status = mxy_pkg::STAT_BAD_ARRIVAL;
            end
            else if (arr == mxy_pkg::DIR_NORTH)
                mask[mxy_pkg::DIR_SOUTH] = connected_q[mxy_pkg::DIR_SOUTH];
            else if (arr == mxy_pkg::DIR_SOUTH)
                mask[mxy_pkg::DIR_NORTH] = connected_q[mxy_pkg::DIR_NORTH];
            else
            begin
                for (int i = 0; i < mxy_pkg::ROUTER_PORTS; i++)
                    if (i != arr && connected_q[i])
                        mask[i] = 1'b1;
            end
            r.mask = mask;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            router_number_q = '0;
            local_ports_q = mxy_pkg::LPC_W'(1);
            port_total_q = mxy_pkg::PT_W'(5);
            mesh_width_q = mxy_pkg::MW_W'(1);
            connected_q = '0;
            expected_routes.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_routes.size() == 0)
                begin
                    $error("route result with none expected: out_port %0d forward_mask %h status %0d",
                           out_port, forward_mask, status);
                    fail_count++;
                end
                else
                begin
                    oldest_route = expected_routes.pop_front();
                    if (out_port !== oldest_route.port)
                    begin
                        $error("out_port mismatch: expected %0d, actual %0d",
                               oldest_route.port, out_port);
                        fail_count++;
                    end
                    if (forward_mask !== oldest_route.mask)
                    begin
                        $error("forward_mask mismatch: expected %h, actual %h",
                               oldest_route.mask, forward_mask);
                        fail_count++;
                    end
                    if (status !== oldest_route.status)
                    begin
                        $error("status mismatch: expected %0d, actual %0d",
                               oldest_route.status, status);
                        fail_count++;
                    end
                end
            end
            if (req_valid && !req_stall)
                expected_routes.push_back(predict_route(action, destination, arrival_port));
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    mxy_pkg::CFG_ROUTER_NUMBER:
                        router_number_q = cfg_data[mxy_pkg::RN_W-1:0];
                    mxy_pkg::CFG_LOCAL_PORT_COUNT:
                        local_ports_q = cfg_data[mxy_pkg::LPC_W-1:0];
                    mxy_pkg::CFG_PORT_TOTAL:
                        port_total_q = cfg_data[mxy_pkg::PT_W-1:0];
                    mxy_pkg::CFG_MESH_WIDTH:
                        mesh_width_q = cfg_data[mxy_pkg::MW_W-1:0];
                    mxy_pkg::CFG_CONNECTED_MASK:
                        connected_q = cfg_data[mxy_pkg::MASK_W-1:0];
                    default: ;
                endcase
            end
            pending = expected_routes.size();
        end
    end

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// Top of the mesh XY route compute testbench: clock, reset, register setup and header traffic.
// Depends on mxy_pkg, mesh_xy_route_compute and mesh_route_checker.

module tb;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 24;
    localparam int HOLD_CYCLES  = 160;
    localparam int PHASE_ITEMS  = 80;
    localparam int NUM_PHASES   = 8;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [mxy_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [mxy_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                           req_valid;
    logic                           req_stall;
    logic                           action;
    logic [mxy_pkg::DEST_W-1:0]     destination;
    logic [mxy_pkg::PORT_W-1:0]     arrival_port;
    logic                           rsp_valid;
    logic                           rsp_stall;
    logic [mxy_pkg::PORT_W-1:0]     out_port;
    logic [mxy_pkg::MASK_W-1:0]     forward_mask;
    logic [mxy_pkg::STAT_W-1:0]     status;

    int fail_count;
    int pending;
    int cycle_count;
    int burst_left;
    int unicast_count;
    int broadcast_count;
    int setting_count;
    int cur_rn, cur_lpc, cur_mw;
    int stall_mode, stall_run;
    bit hold_request;
    bit hold_done;

    mesh_xy_route_compute dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .action       (action),
        .destination  (destination),
        .arrival_port (arrival_port),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .out_port     (out_port),
        .forward_mask (forward_mask),
        .status       (status)
    );

    mesh_route_checker route_chk
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .action       (action),
        .destination  (destination),
        .arrival_port (arrival_port),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .out_port     (out_port),
        .forward_mask (forward_mask),
        .status       (status),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles with %0d route results outstanding",
                 cycle_count, pending);
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        rsp_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_request && !hold_done)
            begin
                hold_done = 1'b1;
                repeat (HOLD_CYCLES)
                begin
                    @(negedge clk);
                    rsp_stall <= 1'b1;
                end
            end
            else
            begin
                stall_mode = $urandom_range(0, 3);
                stall_run = $urandom_range(1, 40);
                repeat (stall_run)
                begin
                    @(negedge clk);
                    case (stall_mode)
                        0:       rsp_stall <= 1'b0;
                        1:       rsp_stall <= $urandom_range(0, 1);
                        2:       rsp_stall <= ($urandom_range(0, 3) != 0);
                        default: rsp_stall <= ~rsp_stall;
                    endcase
                end
            end
        end
    end

    task automatic write_reg(input logic [mxy_pkg::CFG_IDX_W-1:0] idx, input int value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= mxy_pkg::CFG_DATA_W'(value);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_setting(input int rn, input int lpc, input int pt, input int mw,
                                 input int conn);
        write_reg(mxy_pkg::CFG_ROUTER_NUMBER, rn);
        write_reg(mxy_pkg::CFG_LOCAL_PORT_COUNT, lpc);
        write_reg(mxy_pkg::CFG_PORT_TOTAL, pt);
        write_reg(mxy_pkg::CFG_MESH_WIDTH, mw);
        write_reg(mxy_pkg::CFG_CONNECTED_MASK, conn);
        cur_rn = rn;
        cur_lpc = lpc;
        cur_mw = mw;
        setting_count++;
    endtask

    task automatic send_header(input logic act, input logic [mxy_pkg::DEST_W-1:0] dest,
                               input logic [mxy_pkg::PORT_W-1:0] arr);
        int gap;
        @(negedge clk);
        req_valid <= 1'b1;
        action <= act;
        destination <= dest;
        arrival_port <= arr;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        if (act)
            broadcast_count++;
        else
            unicast_count++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 30);
            gap = $urandom_range(1, 8);
            @(negedge clk);
            req_valid <= 1'b0;
            repeat (gap - 1)
                @(negedge clk);
        end
    endtask

    task automatic send_random_header();
        int lpc, w, target, pick;
        logic [mxy_pkg::DEST_W-1:0] dest;
        lpc = (cur_lpc == 0) ? 1 : cur_lpc;
        w = (cur_mw == 0) ? 1 : cur_mw;
        pick = $urandom_range(0, 99);
        dest = mxy_pkg::DEST_W'($urandom);
        target = -1;
        if (pick < 35)
            send_header(1'b1, dest, mxy_pkg::PORT_W'($urandom));
        else
        begin
            // aim at the home router and its neighbors so local ports and all turns occur
            if (pick < 65)
                target = cur_rn;
            else if (pick < 85)
            begin
                case ($urandom_range(0, 3))
                    0:       target = cur_rn - 1;
                    1:       target = cur_rn + 1;
                    2:       target = cur_rn - w;
                    default: target = cur_rn + w;
                endcase
            end
            if (target >= 0)
                dest = mxy_pkg::DEST_W'(target * lpc + int'($urandom_range(0, lpc + 1)));
            send_header(1'b0, dest, mxy_pkg::PORT_W'($urandom));
        end
    endtask

    task automatic end_burst();
        @(negedge clk);
        req_valid <= 1'b0;
        burst_left = 0;
    endtask

    task automatic drain();
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES)
            @(negedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        req_valid = 1'b0;
        action = 1'b0;
        destination = '0;
        arrival_port = '0;
        burst_left = 0;
        unicast_count = 0;
        broadcast_count = 0;
        setting_count = 0;
        hold_request = 1'b0;
        hold_done = 1'b0;
        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // home router 5 at x 1, y 1 in a 4-wide mesh; endpoints 20..23
        apply_setting(5, 4, 7, 4, 16'hA5F7);
        send_header(1'b0, 16'd20, 4'd0);
        send_header(1'b0, 16'd22, 4'd15);
        send_header(1'b0, 16'd23, 4'd0);
        send_header(1'b0, 16'd16, 4'd0);
        send_header(1'b0, 16'd24, 4'd0);
        send_header(1'b0, 16'd4, 4'd0);
        send_header(1'b0, 16'd36, 4'd0);
        send_header(1'b0, 16'h0000, 4'd0);
        send_header(1'b0, 16'hFFFF, 4'd15);
        for (int a = 0; a < 16; a++)
            send_header(1'b1, (a % 2) ? 16'hFFFF : 16'h0000, mxy_pkg::PORT_W'(a));

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            end_burst();
            drain();
            case (ph)
                0:       apply_setting(0, 1, 4, 1, 16'h0000);
                1:       apply_setting(4095, 12, 16, 4096, 16'hFFFF);
                2:       apply_setting(0, 0, 31, 0, int'($urandom_range(0, 65535)));
                3:       apply_setting(4095, 15, 20, 8191, 16'h5555);
                4:       apply_setting(37, 3, 2, 8, int'($urandom_range(0, 65535)));
                default: apply_setting(int'($urandom_range(0, 63)), int'($urandom_range(1, 12)),
                                       int'($urandom_range(4, 16)), int'($urandom_range(1, 12)),
                                       int'($urandom_range(0, 65535)));
            endcase
            if (ph == 1)
                hold_request = 1'b1;
            repeat (PHASE_ITEMS)
                send_random_header();
        end

        end_burst();
        drain();
        $display("Routed %0d unicast and %0d broadcast headers over %0d register settings,",
                 unicast_count, broadcast_count, setting_count);
        $display("including a %0d-cycle receiver hold-off with the sender still offering.",
                 HOLD_CYCLES);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+src
src/mxy_pkg.sv
src/mesh_xy_route_compute.sv
dv/mesh_route_checker.sv
dv/tb.sv
